/* src/mie_pkg.sv */
// ---------------------------------------------------------------------------
// mie_pkg: shared types and constants for the modular inverse core
// Holds the default operand width and the sequencer state encoding.
// ---------------------------------------------------------------------------
package mie_pkg;

	localparam int unsigned WIDTH_DEF = 63;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_DIV,
		ST_UPDATE,
		ST_FIX,
		ST_DONE
	} mie_state_t;

	// Control from the sequencer to the divider.
	typedef struct packed {
		logic start;
	} mie_div_ctrl_t;

	// Status from the divider back to the sequencer. The quotient bit is
	// meaningful while step is high.
	typedef struct packed {
		logic done;
		logic step;
		logic qbit;
	} mie_div_stat_t;

endpackage

/* src/mie_if.sv */
// ---------------------------------------------------------------------------
// mie_stream_if: valid/ready channel with a generic payload
// Used for both the input and the result channel of the inverse core.
// ---------------------------------------------------------------------------
interface mie_stream_if #(
	parameter int unsigned PW = 63
);
	logic          valid;
	logic          ready;
	logic [PW-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/mie_divider.sv */
// ---------------------------------------------------------------------------
// mie_divider: shared restoring divider, one quotient bit per cycle
// Computes the remainder of two unsigned operands and hands
// out each quotient bit, most significant first, as it is decided.
// ---------------------------------------------------------------------------
module mie_divider #(
	parameter int unsigned W = mie_pkg::WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mie_pkg::mie_div_ctrl_t ctrl,
	input  logic [W-1:0]          dividend,
	input  logic [W-1:0]          divisor,
	output mie_pkg::mie_div_stat_t stat,
	output logic [W-1:0]          remainder
);
	import mie_pkg::*;

	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	// Shift in the next dividend bit and try a subtraction.
	always_comb begin
		trial = {rem_q, quo_q[W-1]};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign stat.done = done_q;
	assign stat.step = busy_q;
	assign stat.qbit = !diff[W];
	assign remainder = rem_q;

	property p_no_start_busy;
		@(posedge clk) disable iff (!arst_n) ctrl.start |-> !busy_q;
	endproperty
	a_no_start_busy: assert property (p_no_start_busy)
		else $error("divider started while busy");

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q);
	endproperty
	a_done_after_busy: assert property (p_done_after_busy)
		else $error("divider done without a run");

	property p_done_ends_busy;
		@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q;
	endproperty
	a_done_ends_busy: assert property (p_done_ends_busy)
		else $error("divider busy after done");
endmodule

/* src/modular_inverse_ext_euclid_core.sv */
// ---------------------------------------------------------------------------
// modular_inverse_ext_euclid_core: modular inverse by extended Euclid
// Sequencer and coefficient registers around one shared serial divider.
// ---------------------------------------------------------------------------
// One item is taken at a time. The value is first reduced modulo the modulus
// with one division, then each Euclid step performs one division and one
// coefficient update. Divisions run in the shared bit-serial divider, and
// the product of quotient and coefficient is built from the quotient bits
// as they come out of the divider. Each step ends in the update state,
// which starts the next division or, once the remainder is zero, goes on
// to form the result. When the reduced value is zero no Euclid step is
// run, and when the modulus is zero no division is started at all.
// The result waits in an output register; the next beat is taken once the
// result has been delivered.
module modular_inverse_ext_euclid_core #(
	parameter int unsigned WIDTH = mie_pkg::WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [WIDTH-1:0] cfg_wdata,
	mie_stream_if.sink       in_ch,
	mie_stream_if.source     out_ch
);
	import mie_pkg::*;

	mie_state_t    state_q, state_d;
	mie_div_ctrl_t div_ctrl;
	mie_div_stat_t div_stat;

	logic [WIDTH-1:0] modulus_q;
	logic [WIDTH-1:0] r0_q, r1_q;
	logic [WIDTH:0]   t0_q, t1_q;
	logic [WIDTH-1:0] rem;
	logic [WIDTH-1:0] dvd, dvs;
	logic [WIDTH-1:0] inv_q;
	logic             ok_q;
	logic [WIDTH:0]   acc_q;
	logic [WIDTH:0]   t0_fix;
	logic             accept;

	assign accept = in_ch.valid && in_ch.ready;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= WIDTH'(1);
		end else if (cfg_we) begin
			modulus_q <= cfg_wdata;
		end
	end

	// Divider operands: the incoming value and the modulus on the accepting
	// beat, then the remainder pair.
	assign dvd = (state_q == ST_IDLE) ? in_ch.data : r0_q;
	assign dvs = (state_q == ST_IDLE) ? modulus_q : r1_q;

	mie_divider #(.W(WIDTH)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (div_ctrl),
		.dividend  (dvd),
		.divisor   (dvs),
		.stat      (div_stat),
		.remainder (rem)
	);

	// Coefficient update term q*t1, exact modulo 2^(WIDTH+1) since |t| <= m.
	// It is accumulated shift-and-add as the quotient bits come out.
	always_ff @(posedge clk) begin
		if (div_ctrl.start) begin
			acc_q <= '0;
		end else if (state_q == ST_DIV && div_stat.step) begin
			acc_q <= {acc_q[WIDTH-1:0], 1'b0} + (div_stat.qbit ? t1_q : '0);
		end
	end

	assign t0_fix = t0_q[WIDTH] ? t0_q + {1'b0, modulus_q} : t0_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_ch.valid) state_d = (modulus_q == '0) ? ST_FIX : ST_REDUCE;
			ST_REDUCE: if (div_stat.done) state_d = ST_UPDATE;
			ST_DIV:    if (div_stat.done) state_d = ST_UPDATE;
			ST_UPDATE: state_d = (r1_q == '0) ? ST_FIX : ST_DIV;
			ST_FIX:    state_d = ST_DONE;
			ST_DONE:   if (out_ch.ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		div_ctrl.start = 1'b0;
		in_ch.ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready    = 1'b1;
				div_ctrl.start = in_ch.valid && (modulus_q != '0);
			end
			ST_UPDATE: div_ctrl.start = (r1_q != '0);
			default: ;
		endcase
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Remainder and coefficient pairs.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			r0_q <= modulus_q;
			r1_q <= '0;
			t0_q <= '0;
			t1_q <= (WIDTH + 1)'(1);
		end else if (state_q == ST_REDUCE && div_stat.done) begin
			r1_q <= rem;
		end else if (state_q == ST_DIV && div_stat.done) begin
			r0_q <= r1_q;
			r1_q <= rem;
			t0_q <= t1_q;
			t1_q <= t0_q - acc_q;
		end
		if (state_q == ST_FIX) begin
			ok_q  <= (r0_q == WIDTH'(1));
			inv_q <= (r0_q == WIDTH'(1) && modulus_q != WIDTH'(1)) ? t0_fix[WIDTH-1:0] : '0;
		end
	end

	assign out_ch.valid = (state_q == ST_DONE);
	assign out_ch.data  = {ok_q, inv_q};

	property p_busy_not_ready;
		@(posedge clk) disable iff (!arst_n) (state_q != ST_IDLE) |-> !in_ch.ready;
	endproperty
	a_busy_not_ready: assert property (p_busy_not_ready)
		else $error("ready while an item is in work");

	property p_out_only_done;
		@(posedge clk) disable iff (!arst_n) out_ch.valid |-> state_q == ST_DONE;
	endproperty
	a_out_only_done: assert property (p_out_only_done)
		else $error("result shown outside the done state");

	property p_zero_when_none;
		@(posedge clk) disable iff (!arst_n) out_ch.valid && !ok_q |-> inv_q == '0;
	endproperty
	a_zero_when_none: assert property (p_zero_when_none)
		else $error("nonzero inverse without existence");
endmodule
